// ===== rtl/sttd_pkg.sv =====
`default_nettype none

package sttd_pkg;

  localparam int unsigned NumStages   = 8;
  localparam int unsigned SplitStages = 2;
  localparam int unsigned CalStages   = 6;

  // Day split: floor(x / 86400) = floor((x >> 7) * RecipDay >> 35) for x below 2**32.
  localparam logic [16:0] SecsPerDay   = 17'd86400;
  localparam logic [25:0] RecipDay     = 26'd50903317;

  // Day number from 1 Jan 1900 plus the civil offset, with the epoch bias folded in.
  localparam logic [19:0] CivilBase    = 20'd708510;
  localparam logic [21:0] Cent19Base   = 22'd2775843;
  localparam logic [21:0] Cent20Base   = 22'd2921940;
  localparam logic [18:0] Recip4y      = 19'd367469;
  localparam logic [10:0] Days4y       = 11'd1461;
  localparam logic [11:0] RecipMonth   = 12'd3427;
  localparam logic [7:0]  MonthSpan    = 8'd153;
  localparam logic [7:0]  RecipFive    = 8'd205;

  localparam logic [11:0] SecsPerHour  = 12'd3600;
  localparam logic [13:0] RecipHour    = 14'd9321;
  localparam logic [10:0] RecipMin     = 11'd1093;

  typedef logic [15:0] day_num_t;
  typedef logic [16:0] tod_t;
  typedef logic [24:0] date_code_t;
  typedef logic [17:0] time_code_t;

endpackage

`default_nettype wire

// ===== rtl/seconds_to_date_time.sv =====
// Channel | Direction | Handshake               | Payload
// in      | input     | in_valid_i / in_ready_o   | seconds_since_epoch_i[31:0]
// out     | output    | out_valid_o / out_ready_i | date_code_o[24:0], time_code_o[17:0]
//
// One item enters per cycle unless a full pipeline has a stalled output; each
// result passes through the eight-stage pipeline of constant-reciprocal multiplies.
// Reset clears only the per-stage valid bits; the data registers are not reset.
// Each stage loads when it is empty or the stage after it moves, so bubbles close up
// and a stalled output holds its item while earlier stages keep filling.

`default_nettype none

module seconds_to_date_time (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] seconds_since_epoch_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [24:0]      date_code_o,
  output logic [17:0]      time_code_o
);

  localparam int unsigned NS = sttd_pkg::NumStages;
  localparam int unsigned SS = sttd_pkg::SplitStages;

  logic [NS-1:0]         valid_q;
  logic [NS-1:0]         stage_en;
  sttd_pkg::day_num_t    day_num;
  sttd_pkg::tod_t        tod;

  always_comb begin
    stage_en[NS-1] = !valid_q[NS-1] || out_ready_i;
    for (int i = int'(NS) - 2; i >= 0; i--) begin
      stage_en[i] = !valid_q[i] || stage_en[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (stage_en[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int i = 1; i < int'(NS); i++) begin
        if (stage_en[i]) begin
          valid_q[i] <= valid_q[i-1];
        end
      end
    end
  end

  sttd_day_split u_split (
    .clk_i     (clk_i),
    .en_i      (stage_en[SS-1:0]),
    .secs_i    (seconds_since_epoch_i),
    .day_num_o (day_num),
    .tod_o     (tod)
  );

  sttd_date u_date (
    .clk_i       (clk_i),
    .en_i        (stage_en[NS-1:SS]),
    .day_num_i   (day_num),
    .date_code_o (date_code_o)
  );

  sttd_time u_time (
    .clk_i       (clk_i),
    .en_i        (stage_en[NS-1:SS]),
    .tod_i       (tod),
    .time_code_o (time_code_o)
  );

  assign in_ready_o  = stage_en[0];
  assign out_valid_o = valid_q[NS-1];

`ifndef SYNTHESIS
  a_empty_out_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled while the output stage is empty");

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (time_code_o >= 18'd1) && (time_code_o <= 18'd240000))
    else $error("time code out of range");

  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (date_code_o >= 25'd19391231) && (date_code_o <= 25'd20771231))
    else $error("date code out of range");

  a_no_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[NS-2] && !stage_en[NS-1]) |=> valid_q[NS-2])
    else $error("item dropped in front of a stalled output stage");
`endif

endmodule

`default_nettype wire

// ===== rtl/sttd_day_split.sv =====
`default_nettype none

module sttd_day_split (
  input  wire logic                                   clk_i,
  input  wire logic [sttd_pkg::SplitStages-1:0]       en_i,
  input  wire logic [31:0]                            secs_i,
  output sttd_pkg::day_num_t                          day_num_o,
  output sttd_pkg::tod_t                              tod_o
);

  logic [50:0]         quot_prod;
  logic [15:0]         quot_d;
  logic [31:0]         secs_q;
  logic [15:0]         quot_q;
  logic [32:0]         back_prod;
  logic [31:0]         diff;
  logic [16:0]         rem;
  sttd_pkg::day_num_t  day_d, day_q;
  sttd_pkg::tod_t      tod_d, tod_q;

  assign quot_prod = 51'(secs_i[31:7]) * 51'(sttd_pkg::RecipDay);
  assign quot_d    = quot_prod[50:35];

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      secs_q <= secs_i;
      quot_q <= quot_d;
    end
  end

  assign back_prod = 33'(quot_q) * 33'(sttd_pkg::SecsPerDay);
  assign diff      = secs_q - back_prod[31:0];
  assign rem       = diff[16:0];
  assign day_d     = quot_q + 16'(rem != 17'd0);
  assign tod_d     = (rem == 17'd0) ? sttd_pkg::SecsPerDay : rem;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      day_q <= day_d;
      tod_q <= tod_d;
    end
  end

  assign day_num_o = day_q;
  assign tod_o     = tod_q;

endmodule

`default_nettype wire

// ===== rtl/sttd_date.sv =====
`default_nettype none

module sttd_date (
  input  wire logic                                   clk_i,
  input  wire logic [sttd_pkg::CalStages-1:0]         en_i,
  input  wire sttd_pkg::day_num_t                     day_num_i,
  output sttd_pkg::date_code_t                        date_code_o
);

  logic [19:0]  civil_sum;
  logic [21:0]  acc;
  logic         cent20_d, cent20_q3, cent20_q4;
  logic [21:0]  cent_off;
  logic [21:0]  rem_full;
  logic [15:0]  rem_d, rem_q;

  logic [17:0]  acc2;
  logic [36:0]  q4_prod;
  logic [6:0]   q4_d, q4_q;
  logic [17:0]  acc2_q;

  logic [17:0]  q4_days;
  logic [17:0]  doy_full;
  logic [8:0]   doy_d, doy_q;
  logic [11:0]  year_d, year_q5, year_q6;

  logic [10:0]  acc3_d, acc3_q;
  logic [22:0]  mp_prod;
  logic [3:0]   mp_d, mp_q;

  logic [10:0]  mp_span;
  logic [7:0]   day_off;
  logic [15:0]  day_prod;
  logic [4:0]   mday_d, mday_q;
  logic [4:0]   month_raw;
  logic [3:0]   month_d, month_q;
  logic [11:0]  year_d7, year_q7;

  sttd_pkg::date_code_t date_d, date_q;

  assign civil_sum = sttd_pkg::CivilBase + 20'(day_num_i);
  assign acc       = {civil_sum - 20'd1, 2'b11};
  assign cent20_d  = (acc >= sttd_pkg::Cent20Base);
  assign cent_off  = cent20_d ? sttd_pkg::Cent20Base : sttd_pkg::Cent19Base;
  assign rem_full  = acc - cent_off;
  assign rem_d     = rem_full[17:2];

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      cent20_q3 <= cent20_d;
      rem_q     <= rem_d;
    end
  end

  assign acc2    = {rem_q, 2'b11};
  assign q4_prod = 37'(acc2) * 37'(sttd_pkg::Recip4y);
  assign q4_d    = q4_prod[35:29];

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      cent20_q4 <= cent20_q3;
      acc2_q    <= acc2;
      q4_q      <= q4_d;
    end
  end

  assign q4_days  = 18'(q4_q) * 18'(sttd_pkg::Days4y);
  assign doy_full = acc2_q - q4_days + 18'd4;
  assign doy_d    = doy_full[10:2];
  assign year_d   = (cent20_q4 ? 12'd2000 : 12'd1900) + 12'(q4_q);

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      doy_q   <= doy_d;
      year_q5 <= year_d;
    end
  end

  assign acc3_d  = 11'(doy_q) * 11'd5 - 11'd3;
  assign mp_prod = 23'(acc3_d) * 23'(sttd_pkg::RecipMonth);
  assign mp_d    = mp_prod[22:19];

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      acc3_q  <= acc3_d;
      mp_q    <= mp_d;
      year_q6 <= year_q5;
    end
  end

  assign mp_span   = 11'(mp_q) * 11'(sttd_pkg::MonthSpan);
  assign day_off   = 8'(acc3_q - mp_span + 11'd5);
  assign day_prod  = 16'(day_off) * 16'(sttd_pkg::RecipFive);
  assign mday_d    = day_prod[14:10];
  assign month_raw = 5'(mp_q) + 5'd3;
  assign month_d   = (month_raw > 5'd12) ? 4'(month_raw - 5'd12) : month_raw[3:0];
  assign year_d7   = year_q6 + 12'(month_raw > 5'd12);

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      mday_q  <= mday_d;
      month_q <= month_d;
      year_q7 <= year_d7;
    end
  end

  assign date_d = 25'(year_q7) * 25'd10000 + 25'(month_q) * 25'd100 + 25'(mday_q);

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      date_q <= date_d;
    end
  end

  assign date_code_o = date_q;

endmodule

`default_nettype wire

// ===== rtl/sttd_time.sv =====
`default_nettype none

module sttd_time (
  input  wire logic                                   clk_i,
  input  wire logic [sttd_pkg::CalStages-1:0]         en_i,
  input  wire sttd_pkg::tod_t                         tod_i,
  output sttd_pkg::time_code_t                        time_code_o
);

  logic [26:0]  hr_prod;
  logic [4:0]   hr_d, hr_q3, hr_q4, hr_q5, hr_q6;
  logic [16:0]  tod_q;
  logic [16:0]  hr_secs;
  logic [16:0]  min_full;
  logic [11:0]  min_secs_d, min_secs_q4, min_secs_q5;
  logic [20:0]  mn_prod;
  logic [5:0]   mn_d, mn_q5, mn_q6;
  logic [11:0]  mn_secs;
  logic [5:0]   sec_d, sec_q;
  logic [17:0]  hr_part_d, hr_part_q;
  logic [12:0]  ms_part_d, ms_part_q;
  sttd_pkg::time_code_t time_d, time_q;

  assign hr_prod = 27'(tod_i[16:4]) * 27'(sttd_pkg::RecipHour);
  assign hr_d    = hr_prod[25:21];

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      tod_q <= tod_i;
      hr_q3 <= hr_d;
    end
  end

  assign hr_secs    = 17'(hr_q3) * 17'(sttd_pkg::SecsPerHour);
  assign min_full   = tod_q - hr_secs;
  assign min_secs_d = min_full[11:0];

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      hr_q4       <= hr_q3;
      min_secs_q4 <= min_secs_d;
    end
  end

  assign mn_prod = 21'(min_secs_q4[11:2]) * 21'(sttd_pkg::RecipMin);
  assign mn_d    = mn_prod[19:14];

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      hr_q5       <= hr_q4;
      min_secs_q5 <= min_secs_q4;
      mn_q5       <= mn_d;
    end
  end

  assign mn_secs = 12'(mn_q5) * 12'd60;
  assign sec_d   = 6'(min_secs_q5 - mn_secs);

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      hr_q6 <= hr_q5;
      mn_q6 <= mn_q5;
      sec_q <= sec_d;
    end
  end

  assign hr_part_d = 18'(hr_q6) * 18'd10000;
  assign ms_part_d = 13'(mn_q6) * 13'd100 + 13'(sec_q);

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      hr_part_q <= hr_part_d;
      ms_part_q <= ms_part_d;
    end
  end

  assign time_d = hr_part_q + 18'(ms_part_q);

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      time_q <= time_d;
    end
  end

  assign time_code_o = time_q;

endmodule

`default_nettype wire

// ===== tb/sv/tb_seconds_to_date_time.sv =====
`timescale 1ns / 100ps

module tb_seconds_to_date_time;

  localparam longint unsigned DaySecs     = 86400;
  localparam longint unsigned HourSecs    = 3600;
  localparam longint unsigned Day1940     = 14610;
  localparam longint unsigned DayOffset   = 14609;
  localparam longint unsigned CivilShift  = 693901;
  localparam longint unsigned QuadCentury = 146097;
  localparam longint unsigned QuadYear    = 1461;
  localparam longint unsigned FiveMonths  = 153;
  localparam int unsigned     LastDay     = 49710;
  localparam int unsigned     PhaseItems  = 667;
  localparam int unsigned     HoldCycles  = 200;
  localparam int unsigned     CycleLimit  = 100000;

  typedef struct packed {
    logic [31:0]          secs;
    sttd_pkg::date_code_t date_code;
    sttd_pkg::time_code_t time_code;
  } date_time_t;

  logic                 clk_i;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [31:0]          seconds_since_epoch_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  sttd_pkg::date_code_t date_code_o;
  sttd_pkg::time_code_t time_code_o;

  logic [31:0] pending_secs[$];
  date_time_t  expected_dates[$];
  date_time_t  oldest_date;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        hold_rx = 1'b0;
  int unsigned mismatches = 0;
  int unsigned cycle_cnt = 0;

  seconds_to_date_time dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .seconds_since_epoch_i(seconds_since_epoch_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .date_code_o          (date_code_o),
    .time_code_o          (time_code_o)
  );

  function automatic date_time_t convert_seconds(input logic [31:0] secs);
    longint unsigned total, day_n, jd, acc, cent, rem, q4, doy, yr, mp, mo, dy;
    longint unsigned rest, hr, mn;
    date_time_t res;
    total = secs;
    day_n = total / DaySecs;
    if (total % DaySecs != 0) begin
      day_n = day_n + 1;
    end
    jd = DayOffset + day_n;
    acc = 4 * (CivilShift + jd) - 1;
    cent = acc / QuadCentury;
    rem = (acc - QuadCentury * cent) / 4;
    acc = 4 * rem + 3;
    q4 = acc / QuadYear;
    doy = (acc - QuadYear * q4 + 4) / 4;
    yr = 100 * cent + q4;
    acc = 5 * doy - 3;
    mp = acc / FiveMonths;
    dy = (acc - FiveMonths * mp + 5) / 5;
    mo = mp + 3;
    if (mo > 12) begin
      mo = mo - 12;
      yr = yr + 1;
    end
    rest = (total + DaySecs * Day1940 - DaySecs * jd) & 64'hFFFF_FFFF;
    hr = rest / HourSecs;
    rest = rest - hr * HourSecs;
    mn = rest / 60;
    rest = rest - mn * 60;
    res.secs = secs;
    res.date_code = sttd_pkg::date_code_t'(yr * 10000 + mo * 100 + dy);
    res.time_code = sttd_pkg::time_code_t'(hr * 10000 + mn * 100 + rest);
    return res;
  endfunction

  task automatic queue_random(input int unsigned count);
    int unsigned pick;
    longint unsigned day_k;
    longint unsigned secs;
    for (int unsigned i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      day_k = $urandom_range(LastDay);
      if (pick < 40) begin
        secs = $urandom;
      end else if (pick < 65) begin
        secs = day_k * DaySecs;
      end else if (pick < 85) begin
        secs = (day_k % LastDay) * DaySecs + $urandom_range(86399, 1);
      end else if (pick < 93) begin
        secs = (day_k + 1) * DaySecs - 1;
      end else begin
        secs = 64'hFFFF_FFFF - $urandom_range(200000);
      end
      pending_secs.push_back(secs[31:0]);
    end
  endtask

  task automatic wait_accepted();
    while (pending_secs.size() != 0 || in_valid_i) begin
      @(negedge clk_i);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      seconds_since_epoch_i <= '0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_valid_i) begin
        expected_dates.push_back(convert_seconds(seconds_since_epoch_i));
      end
      if (pending_secs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        seconds_since_epoch_i <= pending_secs.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_dates.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Unexpected item: date %0d time %0d", date_code_o, time_code_o);
          end
        end else begin
          oldest_date = expected_dates.pop_front();
          if (date_code_o !== oldest_date.date_code
              || time_code_o !== oldest_date.time_code) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("Mismatch for %0d s: expected %0d %0d, got %0d %0d",
                       oldest_date.secs, oldest_date.date_code,
                       oldest_date.time_code, date_code_o, time_code_o);
            end
          end
        end
      end
      if (hold_rx) begin
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle_pct = 35;
    recv_idle_pct = 62;
    pending_secs.push_back(32'd0);
    pending_secs.push_back(32'd1);
    pending_secs.push_back(32'd3601);
    pending_secs.push_back(32'd86399);
    pending_secs.push_back(32'd86400);
    pending_secs.push_back(32'd86401);
    pending_secs.push_back(32'd5097600);
    pending_secs.push_back(32'd5097601);
    pending_secs.push_back(32'd5184000);
    pending_secs.push_back(32'd5184001);
    pending_secs.push_back(32'd31622400);
    pending_secs.push_back(32'd31622401);
    pending_secs.push_back(32'd1898553601);
    pending_secs.push_back(32'd1898640000);
    pending_secs.push_back(32'd1898640001);
    pending_secs.push_back(32'd4294944000);
    pending_secs.push_back(32'd4294944001);
    pending_secs.push_back(32'hFFFF_FFFF);
    pending_secs.push_back(32'h8000_0000);
    pending_secs.push_back(32'h7FFF_FFFF);
    pending_secs.push_back(32'hAAAA_AAAA);
    pending_secs.push_back(32'h5555_5555);
    queue_random(PhaseItems);
    wait_accepted();

    send_idle_pct = 62;
    recv_idle_pct = 35;
    queue_random(PhaseItems);
    wait_accepted();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(PhaseItems);
    hold_rx = 1'b1;
    repeat (HoldCycles) @(negedge clk_i);
    hold_rx = 1'b0;
    wait_accepted();

    while (expected_dates.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (30) @(negedge clk_i);

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
